@@ src/actk_pkg.sv @@
// ----------------------------------------------------------------------------
// actk_pkg
// Shared types and constants for the alarm clock time keeper.
// ----------------------------------------------------------------------------
`default_nettype none

package actk_pkg;

  localparam int HourW = 5;
  localparam int MinW  = 6;
  localparam int SecW  = 6;

  // last legal value of each time field before rollover
  localparam logic [SecW-1:0]  SecLast  = SecW'(59);
  localparam logic [MinW-1:0]  MinLast  = MinW'(59);
  localparam logic [HourW-1:0] HourLast = HourW'(23);

  // press_seen bit positions
  localparam int PressMinUp   = 0;
  localparam int PressMinDown = 1;
  localparam int PressHourUp  = 2;
  localparam int PressHourDown = 3;
  localparam int PressW       = 4;

  // hours and minutes pair, used for both clock and alarm time
  typedef struct packed {
    logic [HourW-1:0] hours;
    logic [MinW-1:0]  minutes;
  } hm_t;

  // one polled request
  typedef struct packed {
    logic second_tick;
    logic alarm_enable;
    logic adjust_alarm;
    logic minute_up;
    logic minute_down;
    logic hour_up;
    logic hour_down;
  } poll_t;

  // one displayed result
  typedef struct packed {
    logic [HourW-1:0] hours;
    logic [MinW-1:0]  minutes;
    logic [SecW-1:0]  seconds;
    logic [HourW-1:0] alarm_hours;
    logic [MinW-1:0]  alarm_minutes;
    logic             alarm_armed;
    logic             buzzer;
    logic             adjust_marker;
  } disp_t;

  // button levels handed to the adjust logic
  typedef struct packed {
    logic minute_up;
    logic minute_down;
    logic hour_up;
    logic hour_down;
  } btn_t;

endpackage

`default_nettype wire

@@ src/actk_if.sv @@
// ----------------------------------------------------------------------------
// actk_if
// Valid/ready channels for button polls and display results.
// ----------------------------------------------------------------------------
`default_nettype none

interface actk_poll_if;
  logic valid;
  logic ready;
  logic second_tick;
  logic alarm_enable;
  logic adjust_alarm;
  logic minute_up;
  logic minute_down;
  logic hour_up;
  logic hour_down;

  modport source (
    output valid, second_tick, alarm_enable, adjust_alarm,
           minute_up, minute_down, hour_up, hour_down,
    input  ready
  );
  modport sink (
    input  valid, second_tick, alarm_enable, adjust_alarm,
           minute_up, minute_down, hour_up, hour_down,
    output ready
  );
endinterface

interface actk_disp_if;
  logic                        valid;
  logic                        ready;
  logic [actk_pkg::HourW-1:0]  hours;
  logic [actk_pkg::MinW-1:0]   minutes;
  logic [actk_pkg::SecW-1:0]   seconds;
  logic [actk_pkg::HourW-1:0]  alarm_hours;
  logic [actk_pkg::MinW-1:0]   alarm_minutes;
  logic                        alarm_armed;
  logic                        buzzer;
  logic                        adjust_marker;

  modport source (
    output valid, hours, minutes, seconds, alarm_hours, alarm_minutes,
           alarm_armed, buzzer, adjust_marker,
    input  ready
  );
  modport sink (
    input  valid, hours, minutes, seconds, alarm_hours, alarm_minutes,
           alarm_armed, buzzer, adjust_marker,
    output ready
  );
endinterface

`default_nettype wire

@@ src/actk_tick.sv @@
// ----------------------------------------------------------------------------
// actk_tick
// Seconds tick with hh:mm:ss rollover, then the alarm match and buzzer latch.
// ----------------------------------------------------------------------------
`default_nettype none

module actk_tick (
  input  wire logic                       tick,
  input  wire logic                       armed,
  input  wire logic [actk_pkg::SecW-1:0]  seconds,
  input  wire actk_pkg::hm_t              clock_time,
  input  wire actk_pkg::hm_t              alarm_time,
  input  wire logic                       buzzer,
  output logic      [actk_pkg::SecW-1:0]  seconds_next,
  output actk_pkg::hm_t                   clock_next,
  output logic                            buzzer_next
);
  import actk_pkg::*;

  // advance the time by one second when ticked
  always_comb begin
    seconds_next = seconds;
    clock_next   = clock_time;
    if (tick) begin
      if (seconds == SecLast) begin
        seconds_next = '0;
        if (clock_time.minutes == MinLast) begin
          clock_next.minutes = '0;
          if (clock_time.hours == HourLast) begin
            clock_next.hours = '0;
          end else begin
            clock_next.hours = clock_time.hours + HourW'(1);
          end
        end else begin
          clock_next.minutes = clock_time.minutes + MinW'(1);
        end
      end else begin
        seconds_next = seconds + SecW'(1);
      end
    end
  end

  // buzzer latches on a match at the top of the minute, clears when disarmed
  always_comb begin
    if (armed) begin
      buzzer_next = buzzer | ((alarm_time == clock_next) && (seconds_next == '0));
    end else begin
      buzzer_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ src/actk_buttons.sv @@
// ----------------------------------------------------------------------------
// actk_buttons
// Edge-style button stepping of minutes and hours with wrap and carry.
// ----------------------------------------------------------------------------
`default_nettype none

module actk_buttons (
  input  wire actk_pkg::btn_t                 btn,
  input  wire logic [actk_pkg::PressW-1:0]    press_seen,
  input  wire actk_pkg::hm_t                  time_in,
  output logic      [actk_pkg::PressW-1:0]    press_seen_next,
  output actk_pkg::hm_t                       time_out
);
  import actk_pkg::*;

  // up before down, minutes before hours; each button acts once per press
  always_comb begin
    hm_t              t;
    logic [PressW-1:0] s;
    t = time_in;
    s = press_seen;

    // minute up with carry into hours
    if (btn.minute_up) begin
      if (!s[PressMinUp]) begin
        s[PressMinUp] = 1'b1;
        if (t.minutes == MinLast) begin
          t.minutes = '0;
          t.hours   = (t.hours == HourLast) ? '0 : t.hours + HourW'(1);
        end else begin
          t.minutes = t.minutes + MinW'(1);
        end
      end
    end else begin
      s[PressMinUp] = 1'b0;
    end

    // minute down stops at zero
    if (btn.minute_down) begin
      if (t.minutes != '0 && !s[PressMinDown]) begin
        s[PressMinDown] = 1'b1;
        t.minutes       = t.minutes - MinW'(1);
      end
    end else begin
      s[PressMinDown] = 1'b0;
    end

    // hour up wraps
    if (btn.hour_up) begin
      if (!s[PressHourUp]) begin
        s[PressHourUp] = 1'b1;
        t.hours        = (t.hours == HourLast) ? '0 : t.hours + HourW'(1);
      end
    end else begin
      s[PressHourUp] = 1'b0;
    end

    // hour down stops at zero
    if (btn.hour_down) begin
      if (t.hours != '0 && !s[PressHourDown]) begin
        s[PressHourDown] = 1'b1;
        t.hours          = t.hours - HourW'(1);
      end
    end else begin
      s[PressHourDown] = 1'b0;
    end

    time_out        = t;
    press_seen_next = s;
  end

endmodule

`default_nettype wire

@@ src/alarm_clock_time_keeper.sv @@
// ----------------------------------------------------------------------------
// alarm_clock_time_keeper
// 24-hour clock with one alarm, stepped once per polled button request.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  poll    | in  | second tick, alarm switch, adjust switch, four buttons
//  disp    | out | clock hh:mm:ss, alarm hh:mm, armed, buzzer, adjust marker
//
//  A request passes through the request register, then clock/alarm state and
//  the result register are written together.
//  One request per cycle is sustained while disp is ready; the tick and
//  button logic from the request register to the state is a short single pass.
//  Synchronous reset clears time, alarm, press flags and buzzer.
//  A stalled result holds both stages; the request register still takes a
//  new request whenever it is empty or moving on.
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_clock_time_keeper (
  input wire logic clk,
  input wire logic rst,
  actk_poll_if.sink   poll,
  actk_disp_if.source disp
);
  import actk_pkg::*;

  // request register
  logic  req_valid;
  poll_t req;
  logic  advance;

  // clock and alarm state
  logic [SecW-1:0]   clock_seconds;
  hm_t               clock_time;
  hm_t               alarm_time;
  logic [PressW-1:0] press_seen;
  logic              buzzer_latch;

  // result register
  logic  out_valid;
  disp_t out;

  // next values
  logic [SecW-1:0]   seconds_next;
  hm_t               clock_ticked;
  logic              buzzer_next;
  hm_t               adj_in;
  hm_t               adj_out;
  logic [PressW-1:0] press_seen_next;
  hm_t               clock_time_next;
  hm_t               alarm_time_next;
  btn_t              btn;

  assign advance    = req_valid && (!out_valid || disp.ready);
  assign poll.ready = !req_valid || advance;

  // capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (poll.ready) begin
      req_valid <= poll.valid;
    end
    if (poll.ready && poll.valid) begin
      req.second_tick  <= poll.second_tick;
      req.alarm_enable <= poll.alarm_enable;
      req.adjust_alarm <= poll.adjust_alarm;
      req.minute_up    <= poll.minute_up;
      req.minute_down  <= poll.minute_down;
      req.hour_up      <= poll.hour_up;
      req.hour_down    <= poll.hour_down;
    end
  end

  actk_tick u_tick (
    .tick         (req.second_tick),
    .armed        (req.alarm_enable),
    .seconds      (clock_seconds),
    .clock_time   (clock_time),
    .alarm_time   (alarm_time),
    .buzzer       (buzzer_latch),
    .seconds_next (seconds_next),
    .clock_next   (clock_ticked),
    .buzzer_next  (buzzer_next)
  );

  // buttons act on the alarm or the ticked clock time
  assign btn.minute_up   = req.minute_up;
  assign btn.minute_down = req.minute_down;
  assign btn.hour_up     = req.hour_up;
  assign btn.hour_down   = req.hour_down;
  assign adj_in          = req.adjust_alarm ? alarm_time : clock_ticked;

  actk_buttons u_buttons (
    .btn             (btn),
    .press_seen      (press_seen),
    .time_in         (adj_in),
    .press_seen_next (press_seen_next),
    .time_out        (adj_out)
  );

  assign clock_time_next = req.adjust_alarm ? clock_ticked : adj_out;
  assign alarm_time_next = req.adjust_alarm ? adj_out : alarm_time;

  // state update and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_seconds <= '0;
      clock_time    <= '0;
      alarm_time    <= '0;
      press_seen    <= '0;
      buzzer_latch  <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (advance) begin
        clock_seconds <= seconds_next;
        clock_time    <= clock_time_next;
        alarm_time    <= alarm_time_next;
        press_seen    <= press_seen_next;
        buzzer_latch  <= buzzer_next;
        out_valid     <= 1'b1;
      end else if (disp.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out.hours         <= clock_time_next.hours;
      out.minutes       <= clock_time_next.minutes;
      out.seconds       <= seconds_next;
      out.alarm_hours   <= alarm_time_next.hours;
      out.alarm_minutes <= alarm_time_next.minutes;
      out.alarm_armed   <= req.alarm_enable;
      out.buzzer        <= buzzer_next;
      out.adjust_marker <= req.adjust_alarm;
    end
  end

  // drive the result channel
  assign disp.valid         = out_valid;
  assign disp.hours         = out.hours;
  assign disp.minutes       = out.minutes;
  assign disp.seconds       = out.seconds;
  assign disp.alarm_hours   = out.alarm_hours;
  assign disp.alarm_minutes = out.alarm_minutes;
  assign disp.alarm_armed   = out.alarm_armed;
  assign disp.buzzer        = out.buzzer;
  assign disp.adjust_marker = out.adjust_marker;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the alarm clock time keeper. A fixed table of
// button polls opens the run; random polls follow, mixed from noise, press
// bursts, runs of second ticks, alarm set-ups that hit the buzzer and set-ups
// that drive the time through 23:59. A predictor of the clock and alarm state
// supplies the expected display for every accepted request that the table
// does not type out. Both channels idle at random, and the display side holds
// off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import actk_pkg::*;

  localparam int RandomItems = 650;
  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 60;
  localparam int DrainCycles = 10;
  localparam int MaxReported = 40;
  localparam int DirRows     = 20;

  // button masks, ordered {minute up, minute down, hour up, hour down}
  localparam logic [3:0] BtnNone     = 4'b0000;
  localparam logic [3:0] BtnMinUp    = 4'b1000;
  localparam logic [3:0] BtnMinDown  = 4'b0100;
  localparam logic [3:0] BtnHourUp   = 4'b0010;
  localparam logic [3:0] BtnHourDown = 4'b0001;

  localparam disp_t DispZero = '0;
  localparam disp_t DispBuzz = '{hours: '0, minutes: '0, seconds: '0,
                                 alarm_hours: '0, alarm_minutes: '0,
                                 alarm_armed: 1'b1, buzzer: 1'b1,
                                 adjust_marker: 1'b0};

  typedef enum {SegNoise, SegBurst, SegTicks, SegAlarmMatch, SegRollover} seg_kind_t;

  typedef struct packed {
    poll_t req;
    logic  typed;
    disp_t res;
  } dir_row_t;

  // request bits: tick, enable, adjust, min up, min down, hour up, hour down
  localparam dir_row_t DirTable [DirRows] = '{
    '{7'b0000000, 1'b1, DispZero},  // idle straight after reset
    '{7'b0000101, 1'b1, DispZero},  // both downs at zero do nothing
    '{7'b0100000, 1'b1, DispBuzz},  // armed, 00:00 matches 00:00:00
    '{7'b0000000, 1'b1, DispZero},  // disarm clears the buzzer
    '{7'b0011100, 1'b0, DispZero},  // alarm: minute up then down in one poll
    '{7'b0011100, 1'b0, DispZero},  // held, no repeat
    '{7'b0010100, 1'b0, DispZero},
    '{7'b0011110, 1'b0, DispZero},
    '{7'b0010001, 1'b0, DispZero},
    '{7'b1000000, 1'b0, DispZero},
    '{7'b1000010, 1'b0, DispZero},
    '{7'b1000010, 1'b0, DispZero},
    '{7'b1001011, 1'b0, DispZero},
    '{7'b0001111, 1'b0, DispZero},
    '{7'b0000000, 1'b0, DispZero},
    '{7'b1111111, 1'b0, DispZero},
    '{7'b1111111, 1'b0, DispZero},
    '{7'b0110000, 1'b0, DispZero},
    '{7'b0100000, 1'b0, DispZero},
    '{7'b0000000, 1'b0, DispZero}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  actk_poll_if poll_ch ();
  actk_disp_if disp_ch ();

  alarm_clock_time_keeper dut (
    .clk  (clk),
    .rst  (rst),
    .poll (poll_ch),
    .disp (disp_ch)
  );

  // predicted clock, alarm and button state
  logic [HourW-1:0]  tk_hour, al_hour;
  logic [MinW-1:0]   tk_min, al_min;
  logic [SecW-1:0]   tk_sec;
  logic [PressW-1:0] held_mask;
  logic              buzz_on;

  disp_t pending_disp [$];
  int polls_sent  = 0;
  int disps_seen  = 0;
  int mismatches  = 0;
  int cycles      = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // buttons act once per press on the selected minutes/hours pair
  function automatic void step_buttons(inout logic [MinW-1:0] mins,
                                       inout logic [HourW-1:0] hrs,
                                       input poll_t p);
    if (p.minute_up) begin
      if (mins <= MinLast && !held_mask[PressMinUp]) begin
        held_mask[PressMinUp] = 1'b1;
        mins = mins + MinW'(1);
      end
      if (mins > MinLast) begin
        mins = '0;
        hrs = (hrs >= HourLast) ? '0 : hrs + HourW'(1);
      end
    end else begin
      held_mask[PressMinUp] = 1'b0;
    end
    if (p.minute_down) begin
      if (mins != '0 && !held_mask[PressMinDown]) begin
        held_mask[PressMinDown] = 1'b1;
        mins = mins - MinW'(1);
      end
    end else begin
      held_mask[PressMinDown] = 1'b0;
    end
    if (p.hour_up) begin
      if (hrs <= HourLast && !held_mask[PressHourUp]) begin
        held_mask[PressHourUp] = 1'b1;
        hrs = hrs + HourW'(1);
      end
      if (hrs > HourLast) hrs = '0;
    end else begin
      held_mask[PressHourUp] = 1'b0;
    end
    if (p.hour_down) begin
      if (hrs != '0 && !held_mask[PressHourDown]) begin
        held_mask[PressHourDown] = 1'b1;
        hrs = hrs - HourW'(1);
      end
    end else begin
      held_mask[PressHourDown] = 1'b0;
    end
  endfunction

  // tick, then buzzer, then buttons; returns the display after the poll
  function automatic disp_t advance_clock(input poll_t p);
    disp_t d;
    if (p.second_tick) begin
      if (tk_sec == SecLast) begin
        tk_sec = '0;
        if (tk_min == MinLast) begin
          tk_min = '0;
          tk_hour = (tk_hour == HourLast) ? '0 : tk_hour + HourW'(1);
        end else begin
          tk_min = tk_min + MinW'(1);
        end
      end else begin
        tk_sec = tk_sec + SecW'(1);
      end
    end
    if (!p.alarm_enable) begin
      buzz_on = 1'b0;
    end else if (al_hour == tk_hour && al_min == tk_min && tk_sec == '0) begin
      buzz_on = 1'b1;
    end
    if (p.adjust_alarm) step_buttons(al_min, al_hour, p);
    else step_buttons(tk_min, tk_hour, p);
    d.hours         = tk_hour;
    d.minutes       = tk_min;
    d.seconds       = tk_sec;
    d.alarm_hours   = al_hour;
    d.alarm_minutes = al_min;
    d.alarm_armed   = p.alarm_enable;
    d.buzzer        = buzz_on;
    d.adjust_marker = p.adjust_alarm;
    return d;
  endfunction

  function automatic poll_t make_poll(input logic tick, input logic en,
                                      input logic adj, input logic [3:0] btn);
    return poll_t'({tick, en, adj, btn});
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MaxReported) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s is %0d, expected %0d",
                                disps_seen, name, got, want));
  endtask

  // offer one request after a gap, random but for polls 130-329; predict once taken
  task automatic send_poll(input poll_t p, input logic typed = 1'b0,
                           input disp_t res = '0);
    int gap;
    disp_t pred;
    gap = (polls_sent >= 130 && polls_sent < 330) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      @(negedge clk);
      poll_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    poll_ch.second_tick  <= p.second_tick;
    poll_ch.alarm_enable <= p.alarm_enable;
    poll_ch.adjust_alarm <= p.adjust_alarm;
    poll_ch.minute_up    <= p.minute_up;
    poll_ch.minute_down  <= p.minute_down;
    poll_ch.hour_up      <= p.hour_up;
    poll_ch.hour_down    <= p.hour_down;
    poll_ch.valid        <= 1'b1;
    do @(posedge clk); while (!poll_ch.ready);
    pred = advance_clock(p);
    pending_disp.push_back(typed ? res : pred);
    polls_sent++;
  endtask

  // press and release until the chosen time reads the goal
  task automatic chase_time(input logic adj, input logic en, input hm_t goal);
    hm_t cur;
    logic [3:0] btn;
    int guard;
    for (guard = 0; guard < 128; guard++) begin
      cur = adj ? hm_t'({al_hour, al_min}) : hm_t'({tk_hour, tk_min});
      if (cur == goal) break;
      btn = BtnNone;
      if (cur.minutes < goal.minutes) btn |= BtnMinUp;
      else if (cur.minutes > goal.minutes) btn |= BtnMinDown;
      if (cur.hours < goal.hours) btn |= BtnHourUp;
      else if (cur.hours > goal.hours) btn |= BtnHourDown;
      send_poll(make_poll(1'b0, en, adj, btn));
      send_poll(make_poll(1'b0, en, adj, BtnNone));
    end
  endtask

  task automatic play_segment(input seg_kind_t kind);
    int n, i;
    logic adj, en;
    logic [3:0] mask;
    hm_t goal;
    adj = 1'($urandom_range(0, 1));
    en  = 1'($urandom_range(0, 1));
    case (kind)
      SegNoise: begin
        n = $urandom_range(8, 20);
        for (i = 0; i < n; i++) send_poll(poll_t'(7'($urandom_range(0, 127))));
      end
      SegBurst: begin
        mask = 4'($urandom_range(1, 15));
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) begin
          send_poll(make_poll(1'($urandom_range(0, 1)), en, adj, mask));
          send_poll(make_poll(1'($urandom_range(0, 1)), en, adj, BtnNone));
        end
      end
      SegTicks: begin
        n = $urandom_range(20, 70);
        for (i = 0; i < n; i++)
          send_poll(make_poll($urandom_range(0, 7) != 0, en, adj, BtnNone));
      end
      SegAlarmMatch: begin
        // alarm one minute ahead, then tick until the minute turns over
        goal.hours = tk_hour;
        goal.minutes = tk_min + MinW'(1);
        if (tk_min == MinLast) begin
          goal.minutes = '0;
          goal.hours = (tk_hour == HourLast) ? '0 : tk_hour + HourW'(1);
        end
        chase_time(1'b1, 1'b0, goal);
        do send_poll(make_poll(1'b1, 1'b1, adj, BtnNone));
        while (tk_sec != '0);
        repeat (2) send_poll(make_poll(1'b0, 1'b1, adj, BtnNone));
        send_poll(make_poll(1'b0, 1'b0, adj, BtnNone));
      end
      SegRollover: begin
        // bring the time to 23:59, then wrap it with an up button
        goal = '{hours: HourLast, minutes: MinLast};
        chase_time(adj, en, goal);
        case ($urandom_range(0, 2))
          0: mask = BtnMinUp;
          1: mask = BtnHourUp;
          default: mask = BtnMinUp | BtnHourUp;
        endcase
        send_poll(make_poll(1'b0, en, adj, mask));
        send_poll(make_poll(1'b0, en, adj, BtnNone));
      end
      default: ;
    endcase
  endtask

  // stimulus
  initial begin
    int row;
    int pick;
    poll_ch.valid        = 1'b0;
    poll_ch.second_tick  = 1'b0;
    poll_ch.alarm_enable = 1'b0;
    poll_ch.adjust_alarm = 1'b0;
    poll_ch.minute_up    = 1'b0;
    poll_ch.minute_down  = 1'b0;
    poll_ch.hour_up      = 1'b0;
    poll_ch.hour_down    = 1'b0;
    disp_ch.ready        = 1'b0;
    tk_hour   = '0;
    tk_min    = '0;
    tk_sec    = '0;
    al_hour   = '0;
    al_min    = '0;
    held_mask = '0;
    buzz_on   = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    for (row = 0; row < DirRows; row++)
      send_poll(DirTable[row].req, DirTable[row].typed, DirTable[row].res);

    play_segment(SegRollover);
    play_segment(SegAlarmMatch);
    while (polls_sent < DirRows + RandomItems) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) play_segment(SegNoise);
      else if (pick < 6) play_segment(SegBurst);
      else if (pick < 7) play_segment(SegTicks);
      else if (pick < 9) play_segment(SegAlarmMatch);
      else play_segment(SegRollover);
    end
    @(negedge clk);
    poll_ch.valid <= 1'b0;

    while (pending_disp.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending_disp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // display side: random stalls, one long hold-off, one stretch with none
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (!held && disps_seen >= 150) begin
        held = 1'b1;
        stall = HoldCycles;
      end else if (disps_seen >= 400 && disps_seen < 480) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 16);
      end
      if (stall > 0) begin
        @(negedge clk);
        disp_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      disp_ch.ready <= 1'b1;
      do @(posedge clk); while (!disp_ch.valid);
    end
  end

  // compare each delivered display with the oldest prediction
  always @(posedge clk) begin
    disp_t want;
    if (!rst && disp_ch.valid && disp_ch.ready) begin
      disps_seen++;
      if (pending_disp.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request waiting",
                                  disps_seen));
      end else begin
        want = pending_disp.pop_front();
        compare_field("hours", 8'(disp_ch.hours), 8'(want.hours));
        compare_field("minutes", 8'(disp_ch.minutes), 8'(want.minutes));
        compare_field("seconds", 8'(disp_ch.seconds), 8'(want.seconds));
        compare_field("alarm_hours", 8'(disp_ch.alarm_hours),
                      8'(want.alarm_hours));
        compare_field("alarm_minutes", 8'(disp_ch.alarm_minutes),
                      8'(want.alarm_minutes));
        compare_field("alarm_armed", 8'(disp_ch.alarm_armed),
                      8'(want.alarm_armed));
        compare_field("buzzer", 8'(disp_ch.buzzer), 8'(want.buzzer));
        compare_field("adjust_marker", 8'(disp_ch.adjust_marker),
                      8'(want.adjust_marker));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

`default_nettype wire
